/* rtl/core/qbrf_pkg.sv */
// Shared types and constants for the quartic bisection root finder.
// Holds the controller states, command and status structs and register codes.
// No dependencies.
`timescale 1ns / 1ps

package qbrf_pkg;

    // Fixed widths of the evaluation datapath and of the narrow registers.
    localparam int ACC_W      = 64;
    localparam int CHUNK_W    = 32;
    localparam int TOL_W      = 13;
    localparam int ITER_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int STEP_W     = 2;

    localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

    // Register reset values, truncated to the coefficient width on use.
    localparam logic signed [ACC_W-1:0] COEF_X4_RST = 64'sd65536;
    localparam logic signed [ACC_W-1:0] COEF_X3_RST = -64'sd327680;
    localparam logic signed [ACC_W-1:0] COEF_X2_RST = 64'sd65536;
    localparam logic signed [ACC_W-1:0] COEF_X1_RST = -64'sd524288;
    localparam logic signed [ACC_W-1:0] COEF_X0_RST = 64'sd983040;
    localparam logic [TOL_W-1:0]        TOL_RST     = 13'd1;
    localparam logic [ITER_W-1:0]       LIMIT_RST   = 8'd200;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COEF_X4    = 3'd0,
        CFG_COEF_X3    = 3'd1,
        CFG_COEF_X2    = 3'd2,
        CFG_COEF_X1    = 3'd3,
        CFG_COEF_X0    = 3'd4,
        CFG_TOLERANCE  = 3'd5,
        CFG_ITER_LIMIT = 3'd6
    } t_cfg_reg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_EXACT   = 2'd0,
        ST_TOL     = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // Sign class of a polynomial value.
    typedef enum logic [1:0] {
        SG_ZERO = 2'd0,
        SG_POS  = 2'd1,
        SG_NEG  = 2'd2
    } t_sign;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EV_INIT,
        S_EV_MAG,
        S_EV_MUL,
        S_EV_ACC,
        S_EV_SCALE,
        S_EV_ADD,
        S_SAVE_A,
        S_LOOP,
        S_DECIDE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_load;
        logic    x_from_a;
        logic    acc_init;
        logic    mag_load;
        logic    pp_mul;
        logic    pp_acc;
        logic    scale;
        logic    add;
        logic    save_sa;
        logic    mid_calc;
        logic    bisect;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;
        logic limit_hit;
        logic pp_last;
        logic step_last;
        logic stop;
        logic exact;
    } t_dp_stat;

    // Sign class of a 64-bit two's complement value.
    function automatic t_sign sign_of64(logic [ACC_W-1:0] v);
        t_sign s;
        if (v == '0) begin
            s = SG_ZERO;
        end else if (v[ACC_W-1]) begin
            s = SG_NEG;
        end else begin
            s = SG_POS;
        end
        return s;
    endfunction

endpackage

/* rtl/core/qbrf_ctrl.sv */
// Controller state machine of the quartic bisection root finder.
// Sequences input, Horner evaluation, bisection and the output register.
// Depends on qbrf_pkg.
`timescale 1ns / 1ps

module qbrf_ctrl
    import qbrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    logic    r_first, n_first;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_status    <= ST_EXACT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.invalid ? S_DONE : S_EV_INIT;
            end
            S_EV_INIT:  n_state = S_EV_MAG;
            S_EV_MAG:   n_state = S_EV_MUL;
            S_EV_MUL: begin
                if (i_stat.pp_last) begin
                    n_state = S_EV_ACC;
                end
            end
            S_EV_ACC:   n_state = S_EV_SCALE;
            S_EV_SCALE: n_state = S_EV_ADD;
            S_EV_ADD: begin
                if (i_stat.step_last) begin
                    n_state = r_first ? S_SAVE_A : S_DECIDE;
                end else begin
                    n_state = S_EV_MAG;
                end
            end
            S_SAVE_A:   n_state = S_LOOP;
            S_LOOP: begin
                n_state = i_stat.limit_hit ? S_DONE : S_EV_INIT;
            end
            S_DECIDE: begin
                n_state = i_stat.stop ? S_DONE : S_LOOP;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands and control register updates.
    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        n_first          = r_first;
        n_status         = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_load = i_in_valid;
            end
            S_CHECK: begin
                if (i_stat.invalid) begin
                    n_status = ST_INVALID;
                end else begin
                    o_cmd.x_from_a = 1'b1;
                    n_first        = 1'b1;
                end
            end
            S_EV_INIT:  o_cmd.acc_init = 1'b1;
            S_EV_MAG:   o_cmd.mag_load = 1'b1;
            S_EV_MUL:   o_cmd.pp_mul   = 1'b1;
            S_EV_ACC:   o_cmd.pp_acc   = 1'b1;
            S_EV_SCALE: o_cmd.scale    = 1'b1;
            S_EV_ADD:   o_cmd.add      = 1'b1;
            S_SAVE_A:   o_cmd.save_sa  = 1'b1;
            S_LOOP: begin
                if (i_stat.limit_hit) begin
                    n_status = ST_LIMIT;
                end else begin
                    o_cmd.mid_calc = 1'b1;
                    n_first        = 1'b0;
                end
            end
            S_DECIDE: begin
                if (i_stat.stop) begin
                    n_status = i_stat.exact ? ST_EXACT : ST_TOL;
                end else begin
                    o_cmd.bisect = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The output register holds a word until the consumer takes it.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // A loaded result is presented in the following cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise output valid");

    // Partial products run only right after the magnitudes are formed.
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_MUL) |->
            ($past(r_state) == S_EV_MAG || $past(r_state) == S_EV_MUL))
        else $error("multiply state entered out of order");

    // With a free output register the finished word leaves at once.
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_state == S_IDLE))
        else $error("done state stalled with a free output register");

endmodule

/* rtl/core/qbrf_datapath.sv */
// Datapath of the quartic bisection root finder: registers, interval,
// shared 32x32 multiplier for Horner steps, saturation and output word.
// Depends on qbrf_pkg.
`timescale 1ns / 1ps

module qbrf_datapath
    import qbrf_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [VALUE_WIDTH-1:0] i_cfg_wdata,
    input  logic [VALUE_WIDTH-1:0] i_lower_bound,
    input  logic [VALUE_WIDTH-1:0] i_upper_bound,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic [VALUE_WIDTH-1:0] o_root,
    output logic [1:0]             o_status,
    output logic [ITER_W-1:0]      o_iterations
);

    localparam int XC     = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int NPP    = 2 * XC;
    localparam int PP_W   = $clog2(NPP);
    localparam int SH_W   = $clog2(XC + 1);
    localparam int PROD_W = ACC_W + XC * CHUNK_W;
    localparam int VW     = VALUE_WIDTH;

    localparam logic [PP_W-1:0] PP_LAST = PP_W'(NPP - 1);

    // Configuration registers.
    logic [VW-1:0]     r_c4, r_c3, r_c2, r_c1, r_c0;
    logic [TOL_W-1:0]  r_tol;
    logic [ITER_W-1:0] r_limit;

    // Interval and evaluation state.
    logic [VW-1:0]                  r_a, r_b, r_x, r_m, r_h;
    logic [ACC_W-1:0]               r_acc, r_sc, r_pp;
    logic [1:0][CHUNK_W-1:0]        r_amag;
    logic [XC-1:0][CHUNK_W-1:0]     r_xmag;
    logic                           r_neg;
    logic [SH_W-1:0]                r_pp_sh;
    logic [PROD_W-1:0]              r_prod;
    logic [PP_W-1:0]                r_pp_idx;
    logic [STEP_W-1:0]              r_step;
    t_sign                          r_sa;
    logic [ITER_W-1:0]              r_iter;

    // Output word.
    logic [VW-1:0]     r_root;
    t_status           r_status;
    logic [ITER_W-1:0] r_iter_out;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4    <= VW'(COEF_X4_RST);
            r_c3    <= VW'(COEF_X3_RST);
            r_c2    <= VW'(COEF_X2_RST);
            r_c1    <= VW'(COEF_X1_RST);
            r_c0    <= VW'(COEF_X0_RST);
            r_tol   <= TOL_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COEF_X4:    r_c4    <= i_cfg_wdata;
                CFG_COEF_X3:    r_c3    <= i_cfg_wdata;
                CFG_COEF_X2:    r_c2    <= i_cfg_wdata;
                CFG_COEF_X1:    r_c1    <= i_cfg_wdata;
                CFG_COEF_X0:    r_c0    <= i_cfg_wdata;
                CFG_TOLERANCE:  r_tol   <= i_cfg_wdata[TOL_W-1:0];
                CFG_ITER_LIMIT: r_limit <= i_cfg_wdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Magnitudes and product sign of the next Horner multiply.
    logic [ACC_W-1:0] w_acc_mag;
    logic [VW-1:0]    w_x_mag;
    assign w_acc_mag = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
    assign w_x_mag   = r_x[VW-1] ? (VW'(0) - r_x) : r_x;

    // One 32x32 partial product per cycle from the chunk pair at r_pp_idx.
    logic [CHUNK_W-1:0] w_a_chunk, w_x_chunk;
    logic [SH_W-1:0]    w_xi;
    logic [ACC_W-1:0]   w_pp;
    logic [SH_W-1:0]    w_sh;

    assign w_a_chunk = r_amag[r_pp_idx[0]];

    if (XC == 1) begin : g_x_one
        assign w_x_chunk = r_xmag[0];
        assign w_xi      = '0;
    end else begin : g_x_multi
        assign w_x_chunk = r_xmag[r_pp_idx[PP_W-1:1]];
        assign w_xi      = SH_W'(r_pp_idx[PP_W-1:1]);
    end

    assign w_pp = ACC_W'(w_a_chunk) * ACC_W'(w_x_chunk);
    assign w_sh = SH_W'(r_pp_idx[0]) + w_xi;

    // Previous partial product placed at its chunk offset.
    logic [PROD_W-1:0] w_pp_shifted;
    assign w_pp_shifted = PROD_W'(r_pp) << (r_pp_sh * CHUNK_W);

    // Drop the fraction bits and saturate the magnitude to the signed range.
    logic             w_ovf, w_over_lim;
    logic [ACC_W-1:0] w_q, w_qs, w_sc;
    assign w_ovf      = |r_prod[PROD_W-1:ACC_W+FRAC_BITS];
    assign w_q        = r_prod[ACC_W+FRAC_BITS-1:FRAC_BITS];
    assign w_over_lim = r_neg ? (w_q[ACC_W-1] && (|w_q[ACC_W-2:0])) : w_q[ACC_W-1];
    assign w_qs       = (w_ovf || w_over_lim) ? (r_neg ? ACC_MIN : ACC_MAX) : w_q;
    assign w_sc       = r_neg ? (ACC_W'(0) - w_qs) : w_qs;

    // Coefficient of this Horner step, sign extended.
    logic [VW-1:0]    w_coef;
    logic [ACC_W-1:0] w_coef64, w_sum, w_sat;
    always_comb begin
        unique case (r_step)
            2'd0:    w_coef = r_c3;
            2'd1:    w_coef = r_c2;
            2'd2:    w_coef = r_c1;
            default: w_coef = r_c0;
        endcase
    end
    assign w_coef64 = {{(ACC_W-VW){w_coef[VW-1]}}, w_coef};
    assign w_sum    = r_sc + w_coef64;

    // Saturating add.
    always_comb begin
        if ((r_sc[ACC_W-1] == w_coef64[ACC_W-1]) && (w_sum[ACC_W-1] != r_sc[ACC_W-1])) begin
            w_sat = w_coef64[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sat = w_sum;
        end
    end

    // Half width and midpoint; b > a keeps the difference positive.
    logic [VW:0]   w_diff;
    logic [VW-1:0] w_h, w_m;
    assign w_diff = {r_b[VW-1], r_b} - {r_a[VW-1], r_a};
    assign w_h    = w_diff[VW:1];
    assign w_m    = r_a + w_h;

    t_sign w_sm;
    assign w_sm = sign_of64(r_acc);

    // Horner evaluation and bisection registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_idx <= '0;
            r_step   <= '0;
            r_iter   <= '0;
        end else begin
            if (i_cmd.in_load) begin
                r_a    <= i_lower_bound;
                r_b    <= i_upper_bound;
                r_iter <= '0;
            end
            if (i_cmd.x_from_a) begin
                r_x <= r_a;
            end
            if (i_cmd.acc_init) begin
                r_acc  <= {{(ACC_W-VW){r_c4[VW-1]}}, r_c4};
                r_step <= '0;
            end
            if (i_cmd.mag_load) begin
                r_amag   <= w_acc_mag;
                r_xmag   <= (XC * CHUNK_W)'(w_x_mag);
                r_neg    <= r_acc[ACC_W-1] ^ r_x[VW-1];
                r_pp     <= '0;
                r_pp_sh  <= '0;
                r_prod   <= '0;
                r_pp_idx <= '0;
            end
            // Multiply the next chunk pair while the previous one is summed.
            if (i_cmd.pp_mul) begin
                r_pp     <= w_pp;
                r_pp_sh  <= w_sh;
                r_prod   <= r_prod + w_pp_shifted;
                r_pp_idx <= r_pp_idx + 1'b1;
            end
            if (i_cmd.pp_acc) begin
                r_prod <= r_prod + w_pp_shifted;
            end
            if (i_cmd.scale) begin
                r_sc <= w_sc;
            end
            if (i_cmd.add) begin
                r_acc  <= w_sat;
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.save_sa) begin
                r_sa <= w_sm;
            end
            if (i_cmd.mid_calc) begin
                r_h <= w_h;
                r_m <= w_m;
                r_x <= w_m;
            end
            // Keep the half where the sign changes.
            if (i_cmd.bisect) begin
                r_iter <= r_iter + 1'b1;
                if (w_sm == r_sa) begin
                    r_a  <= r_m;
                    r_sa <= w_sm;
                end else begin
                    r_b <= r_m;
                end
            end
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status   <= i_cmd.out_status;
            r_iter_out <= r_iter;
            if (i_cmd.out_status == ST_EXACT || i_cmd.out_status == ST_TOL) begin
                r_root <= r_m;
            end else begin
                r_root <= '0;
            end
        end
    end

    // Status toward the controller.
    assign o_stat.invalid   = ($signed(r_a) >= $signed(r_b));
    assign o_stat.limit_hit = (r_iter >= r_limit);
    assign o_stat.pp_last   = (r_pp_idx == PP_LAST);
    assign o_stat.step_last = (r_step == STEP_LAST);
    assign o_stat.exact     = (w_sm == SG_ZERO);
    assign o_stat.stop      = (w_sm == SG_ZERO) || (r_h < VW'(r_tol));

    assign o_root       = r_root;
    assign o_status     = r_status;
    assign o_iterations = r_iter_out;

    // The midpoint stays inside the current interval.
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mid_calc |=> ($signed(r_m) >= $signed(r_a) && $signed(r_m) <= $signed(r_b)))
        else $error("midpoint left the interval");

    // No result reports more halving steps than the limit allows.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_iter <= r_limit))
        else $error("iteration count exceeds the limit");

endmodule

/* rtl/core/quartic_bisection_root_finder.sv */
// Top level of the quartic bisection root finder.
// Joins the controller and the datapath; depends on qbrf_pkg, qbrf_ctrl and qbrf_datapath.
//
//   Channel   Handshake                       Word
//   input     i_in_valid / o_in_ready         i_lower_bound, i_upper_bound
//   output    o_out_valid / i_out_ready       o_root, o_status, o_iterations
//   config    i_cfg_we (no wait)              i_cfg_addr, i_cfg_wdata
//
// One polynomial evaluation runs four Horner steps, each of which forms
// 2 * ceil(VALUE_WIDTH / 32) 32x32 partial products on the single shared multiplier
// (2 at the default width). Each halving step evaluates the polynomial once at the
// midpoint, after a first evaluation at the lower bound; an invalid interval goes
// straight to the output register without any evaluation.
// Reset is synchronous and active low and restores the register defaults.
// A new word is taken while a finished one waits in the output register.
`timescale 1ns / 1ps

module quartic_bisection_root_finder
    import qbrf_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [VALUE_WIDTH-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_lower_bound,
    input  logic [VALUE_WIDTH-1:0] i_upper_bound,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_root,
    output logic [1:0]             o_status,
    output logic [ITER_W-1:0]      o_iterations
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    qbrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage.
    qbrf_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_root        (o_root),
        .o_status      (o_status),
        .o_iterations  (o_iterations)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the quartic bisection root finder.
// It drives interval words, predicts each result with its own Horner and bisection
// model, and checks every result word. Depends on qbrf_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;
    import qbrf_pkg::*;

    localparam int FRAC        = 16;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_WORDS = 95;

    // One result word as the block reports it.
    typedef struct packed {
        logic [31:0] root;
        t_status     status;
        logic [7:0]  iters;
    } t_root_word;

    // One row of the directed plan: a register write or an interval word.
    typedef struct {
        logic        is_write;
        t_cfg_reg    sel;
        logic [31:0] data;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        typed;
        t_root_word  want;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_lower_bound;
    logic [31:0] i_upper_bound;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_root;
    logic [1:0]  o_status;
    logic [7:0]  o_iterations;

    // Shadow copy of the configuration registers.
    logic [31:0] coef4, coef3, coef2, coef1, coef0;
    logic [12:0] tol_q;
    logic [7:0]  limit_q;

    t_root_word  pending_roots[$];
    t_root_word  oldest;
    t_plan_row   plan[$];
    int          mismatch_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    logic        hold_req;

    quartic_bisection_root_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_root        (o_root),
        .o_status      (o_status),
        .o_iterations  (o_iterations)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Multiply by x, drop the fraction bits toward zero and clamp to 64 bits.
    function automatic logic [63:0] scale_product(logic [63:0] acc, logic [31:0] x);
        logic         neg;
        logic [63:0]  ma, mx, lim;
        logic [127:0] q;
        neg = acc[63] ^ x[31];
        ma  = acc[63] ? (~acc + 64'd1) : acc;
        mx  = x[31] ? (~{32'hffff_ffff, x} + 64'd1) : {32'd0, x};
        q   = ({64'd0, ma} * {64'd0, mx}) >> FRAC;
        lim = neg ? ACC_MIN : ACC_MAX;
        if (q > {64'd0, lim}) begin
            q = {64'd0, lim};
        end
        return neg ? (~q[63:0] + 64'd1) : q[63:0];
    endfunction

    // Two's complement add that clamps instead of wrapping.
    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return b[63] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    // Sign class of the quartic at x, by Horner's rule.
    function automatic t_sign poly_sign_at(logic [31:0] x);
        logic [63:0] acc;
        acc = {{32{coef4[31]}}, coef4};
        acc = add_clamped(scale_product(acc, x), {{32{coef3[31]}}, coef3});
        acc = add_clamped(scale_product(acc, x), {{32{coef2[31]}}, coef2});
        acc = add_clamped(scale_product(acc, x), {{32{coef1[31]}}, coef1});
        acc = add_clamped(scale_product(acc, x), {{32{coef0[31]}}, coef0});
        if (acc == '0) begin
            return SG_ZERO;
        end
        return acc[63] ? SG_NEG : SG_POS;
    endfunction

    // Full bisection on one interval under the current register settings.
    function automatic t_root_word solve_interval(logic [31:0] lo, logic [31:0] hi);
        t_root_word r;
        longint     a, b, h, m;
        t_sign      sa, sm;
        int         steps;
        a        = longint'($signed(lo));
        b        = longint'($signed(hi));
        steps    = 0;
        r.root   = '0;
        r.status = ST_INVALID;
        r.iters  = '0;
        if (a >= b) begin
            return r;
        end
        sa       = poly_sign_at(lo);
        r.status = ST_LIMIT;
        while (steps < int'(limit_q)) begin
            h  = (b - a) / 2;
            m  = a + h;
            sm = poly_sign_at(m[31:0]);
            if (sm == SG_ZERO || h < longint'(tol_q)) begin
                r.root   = m[31:0];
                r.status = (sm == SG_ZERO) ? ST_EXACT : ST_TOL;
                r.iters  = steps[7:0];
                return r;
            end
            steps++;
            // Keep the upper half only when both ends share a nonzero sign.
            if (sa == sm) begin
                a = m;
            end else begin
                b = m;
            end
        end
        r.iters = steps[7:0];
        return r;
    endfunction

    // Random Q16.16 coefficient between -8.0 and +8.0.
    function automatic logic [31:0] small_coef();
        return 32'($urandom_range(0, 16 << 16)) - 32'(8 << 16);
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Empty plan row, filled in by the builders below.
    function automatic t_plan_row blank_row();
        t_plan_row row;
        row.is_write = 1'b0;
        row.sel      = CFG_COEF_X4;
        row.data     = '0;
        row.lo       = '0;
        row.hi       = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // Directed plan builders.
    task automatic plan_write(t_cfg_reg sel, logic [31:0] data);
        t_plan_row row;
        row          = blank_row();
        row.is_write = 1'b1;
        row.sel      = sel;
        row.data     = data;
        plan.push_back(row);
    endtask

    task automatic plan_word(logic [31:0] lo, logic [31:0] hi);
        t_plan_row row;
        row    = blank_row();
        row.lo = lo;
        row.hi = hi;
        plan.push_back(row);
    endtask

    task automatic plan_known(logic [31:0] lo, logic [31:0] hi, logic [31:0] root,
                              t_status st, logic [7:0] it);
        t_plan_row row;
        row             = blank_row();
        row.lo          = lo;
        row.hi          = hi;
        row.typed       = 1'b1;
        row.want.root   = root;
        row.want.status = st;
        row.want.iters  = it;
        plan.push_back(row);
    endtask

    // Register write; called at a falling edge while the block is idle.
    task automatic write_reg(t_cfg_reg sel, logic [31:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = sel;
        i_cfg_wdata = data;
        case (sel)
            CFG_COEF_X4:    coef4   = data;
            CFG_COEF_X3:    coef3   = data;
            CFG_COEF_X2:    coef2   = data;
            CFG_COEF_X1:    coef1   = data;
            CFG_COEF_X0:    coef0   = data;
            CFG_TOLERANCE:  tol_q   = data[12:0];
            CFG_ITER_LIMIT: limit_q = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offer one interval word, with random gaps, and record its expected result.
    task automatic send_word(logic [31:0] lo, logic [31:0] hi, t_root_word want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_lower_bound = lo;
        i_upper_bound = hi;
        do @(posedge i_clk); while (!o_in_ready);
        pending_roots.push_back(want);
        @(negedge i_clk);
    endtask

    // Wait until every expected word has come back, then let the block settle.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_roots.size() == 0) begin
                note_mismatch("word with none pending", o_root, '0);
            end else begin
                oldest = pending_roots.pop_front();
                if (o_root !== oldest.root) begin
                    note_mismatch("root", o_root, oldest.root);
                end
                if (o_status !== oldest.status) begin
                    note_mismatch("status", 32'(o_status), 32'(oldest.status));
                end
                if (o_iterations !== oldest.iters) begin
                    note_mismatch("iterations", 32'(o_iterations), 32'(oldest.iters));
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus: directed plan, then random phases with fresh settings.
    initial begin
        int          ph;
        int          k;
        int          pick;
        int          center;
        int          w_lo;
        int          w_hi;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_lower_bound  = '0;
        i_upper_bound  = '0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 14;
        recv_idle_pct  = 52;
        coef4   = COEF_X4_RST[31:0];
        coef3   = COEF_X3_RST[31:0];
        coef2   = COEF_X2_RST[31:0];
        coef1   = COEF_X1_RST[31:0];
        coef0   = COEF_X0_RST[31:0];
        tol_q   = TOL_RST;
        limit_q = LIMIT_RST;

        // Reset defaults: invalid intervals, full range, two small intervals and a sub-step interval.
        plan_known(32'd0, 32'd0, 32'd0, ST_INVALID, 8'd0);
        plan_known(32'h7fff_ffff, 32'h8000_0000, 32'd0, ST_INVALID, 8'd0);
        plan_word(32'h8000_0000, 32'h7fff_ffff);
        plan_word(32'd0, 32'(2 << 16));
        plan_word(32'(4 << 16), 32'(6 << 16));
        plan_known(32'hffff_ffff, 32'd0, 32'hffff_ffff, ST_TOL, 8'd0);
        // No iterations allowed at all.
        plan_write(CFG_ITER_LIMIT, 32'd0);
        plan_known(32'd0, 32'(2 << 16), 32'd0, ST_LIMIT, 8'd0);
        // Single iteration with a coarse tolerance.
        plan_write(CFG_ITER_LIMIT, 32'd1);
        plan_write(CFG_TOLERANCE, 32'd6553);
        plan_word(32'h8000_0000, 32'h7fff_ffff);
        plan_word(32'd0, 32'(2 << 16));
        // p(x) = x: the first midpoint of a symmetric interval is an exact root.
        plan_write(CFG_COEF_X4, 32'd0);
        plan_write(CFG_COEF_X3, 32'd0);
        plan_write(CFG_COEF_X2, 32'd0);
        plan_write(CFG_COEF_X1, 32'd65536);
        plan_write(CFG_COEF_X0, 32'd0);
        plan_write(CFG_TOLERANCE, 32'd1);
        plan_write(CFG_ITER_LIMIT, 32'd200);
        plan_known(-32'sd65536, 32'd65536, 32'd0, ST_EXACT, 8'd0);
        plan_word(-32'sd65536, 32'(3 << 16));
        plan_word(32'h8000_0000, 32'h7fff_ffff);
        // Zero tolerance never stops on precision, so the limit runs out.
        plan_write(CFG_TOLERANCE, 32'd0);
        plan_write(CFG_ITER_LIMIT, 32'd40);
        plan_known(32'd1, 32'd5, 32'd0, ST_LIMIT, 8'd40);
        // Zero polynomial: every midpoint is a root.
        plan_write(CFG_COEF_X1, 32'd0);
        plan_write(CFG_TOLERANCE, 32'd1);
        plan_write(CFG_ITER_LIMIT, 32'd200);
        plan_known(-32'sd100, 32'd100, 32'd0, ST_EXACT, 8'd0);
        plan_known(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, ST_EXACT, 8'd0);
        // Extreme coefficients drive the accumulator into saturation.
        plan_write(CFG_COEF_X4, 32'h7fff_ffff);
        plan_write(CFG_COEF_X3, 32'h7fff_ffff);
        plan_write(CFG_COEF_X2, 32'h7fff_ffff);
        plan_write(CFG_COEF_X1, 32'h7fff_ffff);
        plan_write(CFG_COEF_X0, 32'h7fff_ffff);
        plan_word(32'h8000_0000, 32'h7fff_ffff);
        plan_word(-32'sd196608, 32'(2 << 16));
        plan_write(CFG_COEF_X4, 32'h8000_0000);
        plan_write(CFG_COEF_X3, 32'h8000_0000);
        plan_write(CFG_COEF_X2, 32'h8000_0000);
        plan_write(CFG_COEF_X1, 32'h8000_0000);
        plan_write(CFG_COEF_X0, 32'h8000_0000);
        plan_word(32'h8000_0000, 32'h7fff_ffff);
        plan_word(32'h7fff_fff0, 32'h7fff_ffff);
        plan_write(CFG_COEF_X4, 32'h7fff_ffff);
        plan_write(CFG_COEF_X2, 32'h7fff_ffff);
        plan_write(CFG_COEF_X0, 32'h7fff_ffff);
        plan_word(32'h8000_0000, 32'h7fff_ffff);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed plan.
        foreach (plan[n]) begin
            if (plan[n].is_write) begin
                wait_idle();
                write_reg(plan[n].sel, plan[n].data);
            end else begin
                send_word(plan[n].lo, plan[n].hi,
                          plan[n].typed ? plan[n].want : solve_interval(plan[n].lo, plan[n].hi));
            end
        end

        // Random phases, each with its own register settings; the idling mix changes every two phases.
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            send_idle_pct = (ph < 2) ? 14 : ((ph < 4) ? 52 : 0);
            recv_idle_pct = (ph < 2) ? 52 : ((ph < 4) ? 14 : 0);
            case (ph)
                0: begin
                    write_reg(CFG_COEF_X4, COEF_X4_RST[31:0]);
                    write_reg(CFG_COEF_X3, COEF_X3_RST[31:0]);
                    write_reg(CFG_COEF_X2, COEF_X2_RST[31:0]);
                    write_reg(CFG_COEF_X1, COEF_X1_RST[31:0]);
                    write_reg(CFG_COEF_X0, COEF_X0_RST[31:0]);
                    write_reg(CFG_TOLERANCE, 32'(TOL_RST));
                    write_reg(CFG_ITER_LIMIT, 32'(LIMIT_RST));
                end
                2: begin
                    // Linear polynomial with a random root.
                    write_reg(CFG_COEF_X4, 32'd0);
                    write_reg(CFG_COEF_X3, 32'd0);
                    write_reg(CFG_COEF_X2, 32'd0);
                    write_reg(CFG_COEF_X1, 32'd65536);
                    write_reg(CFG_COEF_X0, small_coef());
                    write_reg(CFG_TOLERANCE, 32'($urandom_range(1, 64)));
                    write_reg(CFG_ITER_LIMIT, 32'd200);
                end
                3: begin
                    // Wide random coefficients and short limits.
                    write_reg(CFG_COEF_X4, $urandom());
                    write_reg(CFG_COEF_X3, $urandom());
                    write_reg(CFG_COEF_X2, $urandom());
                    write_reg(CFG_COEF_X1, $urandom());
                    write_reg(CFG_COEF_X0, $urandom());
                    write_reg(CFG_TOLERANCE, 32'd6553);
                    write_reg(CFG_ITER_LIMIT, 32'($urandom_range(1, 12)));
                end
                default: begin
                    write_reg(CFG_COEF_X4, small_coef());
                    write_reg(CFG_COEF_X3, small_coef());
                    write_reg(CFG_COEF_X2, small_coef());
                    write_reg(CFG_COEF_X1, small_coef());
                    write_reg(CFG_COEF_X0, small_coef());
                    if (ph == 4) begin
                        write_reg(CFG_TOLERANCE, 32'($urandom_range(1, 16)));
                        write_reg(CFG_ITER_LIMIT, 32'($urandom_range(8, 30)));
                    end else begin
                        write_reg(CFG_TOLERANCE, 32'($urandom_range(1, 6553)));
                        write_reg(CFG_ITER_LIMIT, 32'($urandom_range(24, 200)));
                    end
                end
            endcase
            // Long receiver hold-off so the block fills and stalls its input.
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            for (k = 0; k < PHASE_WORDS; k++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    lo = $urandom();
                    hi = lo - 32'($urandom_range(0, 1000));
                end else if (pick < 20) begin
                    lo = $urandom();
                    hi = $urandom();
                    if ($signed(lo) > $signed(hi)) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end else begin
                    // Intervals around small values, widths from one LSB upward.
                    center = $urandom_range(0, 32 << 16) - (16 << 16);
                    w_lo   = $urandom_range(0, 1 << $urandom_range(0, 20));
                    w_hi   = $urandom_range(1, 1 << $urandom_range(0, 20));
                    lo     = 32'(center - w_lo);
                    hi     = 32'(center + w_hi);
                end
                send_word(lo, hi, solve_interval(lo, hi));
            end
        end

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0 && pending_roots.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* quartic_bisection_root_finder.f */
rtl/core/qbrf_pkg.sv
rtl/core/qbrf_ctrl.sv
rtl/core/qbrf_datapath.sv
rtl/core/quartic_bisection_root_finder.sv
tb/tb_top.sv
